// ===== rtl/pis_pkg.sv =====
package pis_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 12;
    localparam int SLOT_W     = 4;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_SET = 1'b1
    } t_func;

    typedef struct packed {
        logic scan;
        logic lookup;
    } t_pal_cmd;

    typedef struct packed {
        logic done;
        logic full;
    } t_pal_sts;

endpackage

// ===== rtl/pis_palette.sv =====
module pis_palette
    import pis_pkg::*;
#(
    parameter int INDEX_BITS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pal_cmd              i_cmd,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [INDEX_BITS-1:0] i_slot,
    output t_pal_sts              o_sts,
    output logic [INDEX_BITS-1:0] o_slot,
    output logic [VALUE_W-1:0]    o_data
);

    localparam int PAL_SIZE = 1 << INDEX_BITS;
    localparam int CW       = INDEX_BITS + 1;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_SCAN = 3'b010,
        P_READ = 3'b100
    } t_pstate;

    logic [VALUE_W-1:0]    r_mem [PAL_SIZE];
    logic [VALUE_W-1:0]    r_rd;
    logic [VALUE_W-1:0]    r_value;
    logic [VALUE_W-1:0]    n_value;
    t_pstate               r_state;
    t_pstate               n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_ptr;
    logic [CW-1:0]         n_ptr;
    logic                  r_pend;
    logic                  n_pend;
    logic [INDEX_BITS-1:0] r_cmp_idx;
    logic [INDEX_BITS-1:0] n_cmp_idx;

    logic                  hit;
    logic                  more;
    logic                  full;
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_addr;
    logic                  wr_en;

    assign hit    = r_pend && (r_rd == r_value);
    assign more   = r_ptr < r_count;
    assign full   = r_count == CW'(PAL_SIZE);
    assign o_data = (r_count == '0) ? '0 : r_rd;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_cmp_idx = r_cmp_idx;
        n_value   = r_value;
        rd_en     = 1'b0;
        rd_addr   = i_slot;
        wr_en     = 1'b0;
        o_sts     = '0;
        o_slot    = '0;
        unique case (r_state)
            P_IDLE: begin
                if (i_cmd.scan) begin
                    n_state = P_SCAN;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_value = i_value;
                end else if (i_cmd.lookup) begin
                    rd_en   = 1'b1;
                    n_state = P_READ;
                end
            end
            P_READ: begin
                o_sts.done = 1'b1;
                n_state    = P_IDLE;
            end
            P_SCAN: begin
                if (hit) begin
                    o_sts.done = 1'b1;
                    o_slot     = r_cmp_idx;
                    n_state    = P_IDLE;
                end else if (more) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_ptr[INDEX_BITS-1:0];
                    n_cmp_idx = r_ptr[INDEX_BITS-1:0];
                    n_pend    = 1'b1;
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    o_sts.done = 1'b1;
                    n_state    = P_IDLE;
                    if (full) begin
                        o_sts.full = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        o_slot  = r_count[INDEX_BITS-1:0];
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_value   <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[INDEX_BITS-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/paletted_index_store_unit.sv =====
// Palette-compressed entry store. Each entry holds an INDEX_BITS-bit slot into a
// palette of up to 2^INDEX_BITS distinct 32-bit values. s_tuser selects get (0) or
// set (1). A set scans the palette memory one slot per cycle and appends the value
// when it is missing; a full palette rejects the set with status 1 and changes
// nothing. Indices at or above ENTRIES answer zero and change nothing. One item is
// processed at a time, while the last result may still wait at the output: a get
// reads the slot memory and then the palette, a set scans the palette. After reset
// the block clears the slot memory one entry a cycle, with s_tready low.
module paletted_index_store_unit
    import pis_pkg::*;
#(
    parameter int INDEX_BITS = 4,
    parameter int ENTRIES    = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // index[11:0], value[43:12], zero pad
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_value[31:0], slot[35:32], zero pad
    output logic                 m_tuser    // status
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_GET_SLOT = 6'b000100,
        S_GET_PAL  = 6'b001000,
        S_SET      = 6'b010000,
        S_RESP     = 6'b100000
    } t_state;

    logic [INDEX_BITS-1:0] r_slot_mem [ENTRIES];
    logic [INDEX_BITS-1:0] r_slot_rd;

    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         n_clr;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         n_addr;
    logic [VALUE_W-1:0]    r_res_value;
    logic [VALUE_W-1:0]    n_res_value;
    logic [INDEX_BITS-1:0] r_res_slot;
    logic [INDEX_BITS-1:0] n_res_slot;
    logic                  r_res_status;
    logic                  n_res_status;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [M_TDATA_W-1:0]  r_out_tdata;
    logic                  r_out_tuser;

    logic                  accept;
    logic                  in_range;
    logic [INDEX_W-1:0]    in_index;
    logic [VALUE_W-1:0]    in_value;
    logic                  load_out;
    logic                  slot_rd_en;
    logic                  slot_wr_en;
    logic [AW-1:0]         slot_wr_addr;
    logic [INDEX_BITS-1:0] slot_wr_data;

    t_pal_cmd              pal_cmd;
    t_pal_sts              pal_sts;
    logic [INDEX_BITS-1:0] pal_slot;
    logic [VALUE_W-1:0]    pal_data;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W +: VALUE_W];
    assign in_range = 32'(in_index) < 32'(ENTRIES);
    assign s_tready = r_state == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_tdata;
    assign m_tuser  = r_out_tuser;

    pis_palette #(
        .INDEX_BITS (INDEX_BITS)
    ) u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pal_cmd),
        .i_value (in_value),
        .i_slot  (r_slot_rd),
        .o_sts   (pal_sts),
        .o_slot  (pal_slot),
        .o_data  (pal_data)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_addr       = r_addr;
        n_res_value  = r_res_value;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        pal_cmd      = '0;
        slot_rd_en   = 1'b0;
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_addr;
        slot_wr_data = pal_slot;
        load_out     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = r_clr;
                slot_wr_data = '0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == AW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_addr       = AW'(in_index);
                    n_res_value  = '0;
                    n_res_slot   = '0;
                    n_res_status = 1'b0;
                    if (!in_range) begin
                        n_state = S_RESP;
                    end else begin
                        unique case (t_func'(s_tuser))
                            FUNC_GET: begin
                                slot_rd_en = 1'b1;
                                n_state    = S_GET_SLOT;
                            end
                            FUNC_SET: begin
                                pal_cmd.scan = 1'b1;
                                n_state      = S_SET;
                            end
                            default: begin
                                n_state = S_RESP;
                            end
                        endcase
                    end
                end
            end
            S_GET_SLOT: begin
                pal_cmd.lookup = 1'b1;
                n_state        = S_GET_PAL;
            end
            S_GET_PAL: begin
                if (pal_sts.done) begin
                    n_res_value = pal_data;
                    n_res_slot  = r_slot_rd;
                    n_state     = S_RESP;
                end
            end
            S_SET: begin
                if (pal_sts.done) begin
                    n_state = S_RESP;
                    if (pal_sts.full) begin
                        n_res_status = 1'b1;
                    end else begin
                        slot_wr_en = 1'b1;
                        n_res_slot = pal_slot;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || m_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_res_value  <= n_res_value;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_out_tdata <= {{(M_TDATA_W - VALUE_W - SLOT_W){1'b0}},
                            SLOT_W'(r_res_slot), r_res_value};
            r_out_tuser <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_wr_en) begin
            r_slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        if (slot_rd_en) begin
            r_slot_rd <= r_slot_mem[AW'(in_index)];
        end
    end

endmodule

// ===== rtl/pis_checker.sv =====
module pis_checker
    import pis_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while an item is in flight");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("rejected set carries nonzero data");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_tready)
        else $error("input ready before slot memory clear");

endmodule

bind paletted_index_store_unit pis_checker u_pis_checker (.*);

// ===== tb/tb_paletted_index_store_unit.sv =====
module tb_paletted_index_store_unit
    import pis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAL_SLOTS   = 16;
    localparam int ENTRY_COUNT = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [SLOT_W-1:0]  slot;
        logic               status;
    } t_store_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // index[11:0], value[43:12], zero pad
    logic                 s_tuser;   // func
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // read_value[31:0], slot[35:32], zero pad
    logic                 m_tuser;   // status

    logic [VALUE_W-1:0] palette_model [PAL_SLOTS];
    int                 palette_used;
    logic [SLOT_W-1:0]  entry_slots [ENTRY_COUNT];
    t_store_result      pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;
    int get_count;
    int hit_count;
    int append_count;
    int reject_count;

    paletted_index_store_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_store_result predict_access(t_func f, logic [INDEX_W-1:0] idx,
                                                     logic [VALUE_W-1:0] val);
        t_store_result r;
        int hit_slot;
        r = '0;
        hit_slot = -1;
        if (f == FUNC_GET) begin
            r.slot = entry_slots[idx];
            r.read_value = palette_model[entry_slots[idx]];
            get_count++;
            return r;
        end
        for (int i = 0; i < palette_used && hit_slot < 0; i++) begin
            if (palette_model[i] == val) hit_slot = i;
        end
        if (hit_slot >= 0) begin
            hit_count++;
        end else if (palette_used >= PAL_SLOTS) begin
            reject_count++;
            r.status = 1'b1;
            return r;
        end else begin
            hit_slot = palette_used;
            palette_model[hit_slot] = val;
            palette_used++;
            append_count++;
        end
        entry_slots[idx] = hit_slot[SLOT_W-1:0];
        r.slot = hit_slot[SLOT_W-1:0];
        return r;
    endfunction

    function automatic logic palette_holds(logic [VALUE_W-1:0] val);
        for (int i = 0; i < palette_used; i++) begin
            if (palette_model[i] == val) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_access(input t_func f, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-INDEX_W){1'b0}}, val, idx};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_results.push_back(predict_access(f, idx, val));
    endtask

    always @(posedge i_clk) begin
        t_store_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_value %h slot %0d status %0d",
                       m_tdata[VALUE_W-1:0], m_tdata[VALUE_W+:SLOT_W], m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, m_tdata[VALUE_W-1:0]);
                    error_count++;
                end
                if (m_tdata[VALUE_W+:SLOT_W] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_tdata[VALUE_W+:SLOT_W]);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic test_unwritten_reads();
        send_access(FUNC_GET, 12'h000, 32'h0);
        send_access(FUNC_GET, 12'hFFF, 32'hFFFF_FFFF);
        send_access(FUNC_GET, 12'h555, 32'h0);
    endtask

    // first append lands in slot 0, so unwritten entries now read it
    task automatic test_palette_append();
        send_access(FUNC_SET, 12'hFFF, 32'hFFFF_FFFF);
        send_access(FUNC_GET, 12'h000, 32'h0);
        send_access(FUNC_SET, 12'h000, 32'h0);
        send_access(FUNC_SET, 12'h064, 32'hFFFF_FFFF);
        send_access(FUNC_GET, 12'h000, 32'h0);
        send_access(FUNC_GET, 12'h064, 32'h0);
    endtask

    task automatic test_palette_full();
        logic [VALUE_W-1:0] v;
        int idx;
        idx = 1;
        while (palette_used < PAL_SLOTS) begin
            v = $urandom;
            send_access(FUNC_SET, idx[INDEX_W-1:0], v);
            idx++;
        end
        do v = $urandom; while (palette_holds(v));
        send_access(FUNC_SET, 12'h001, v);
        send_access(FUNC_GET, 12'h001, 32'h0);
        send_access(FUNC_SET, 12'h002, palette_model[PAL_SLOTS-1]);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int pick;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] v;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 7) idx = INDEX_W'($urandom_range(0, 63));
            else idx = INDEX_W'($urandom_range(0, ENTRY_COUNT - 1));
            if (pick < 40) begin
                send_access(FUNC_GET, idx, $urandom);
            end else if (pick < 85) begin
                v = palette_model[$urandom_range(0, palette_used - 1)];
                send_access(FUNC_SET, idx, v);
            end else begin
                send_access(FUNC_SET, idx, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= FUNC_GET;
        s_tdata  <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        cycle_count   = 0;
        palette_used  = 0;
        get_count     = 0;
        hit_count     = 0;
        append_count  = 0;
        reject_count  = 0;
        foreach (palette_model[i]) palette_model[i] = '0;
        foreach (entry_slots[i]) entry_slots[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unwritten_reads();
        test_palette_append();
        test_palette_full();
        test_random_traffic(600, 23, 47);
        test_random_traffic(600, 47, 23);
        test_random_traffic(600, 0, 0);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d gets, %0d palette hits, %0d appends, %0d rejected sets",
                 get_count, hit_count, append_count, reject_count);
        $display("palette filled to %0d slots in %0d cycles", palette_used, cycle_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pis_pkg.sv
rtl/pis_palette.sv
rtl/paletted_index_store_unit.sv
rtl/pis_checker.sv
tb/tb_paletted_index_store_unit.sv
